// File: hdl/packed_4bit_power_integrator_top_macros.svh
// Assertion macros for the packed 4-bit power integrator.
`ifndef PACKED_4BIT_POWER_INTEGRATOR_TOP_MACROS_SVH
`define PACKED_4BIT_POWER_INTEGRATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define P4PI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define P4PI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/p4pi_pkg.sv
// Package with types, constants and helpers of the packed 4-bit power integrator.
`timescale 1ns / 1ps
`default_nettype none
package p4pi_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned PairW       = 8;
  localparam int unsigned PowerW      = 8;
  localparam int unsigned AccW        = 26;
  localparam int unsigned SpbW        = 19;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned BoardPorts  = 5;
  localparam int unsigned SumsPerWord = 4;

  localparam int unsigned MaxSamplesDefault = 262144;
  localparam int unsigned NumBoardsDefault  = 5;
  localparam logic [SpbW-1:0] SpbReset      = 19'd18432;

  // One time sample of one channel: one packed word per board.
  typedef struct packed {
    logic [WordW-1:0] word_board4;
    logic [WordW-1:0] word_board3;
    logic [WordW-1:0] word_board2;
    logic [WordW-1:0] word_board1;
    logic [WordW-1:0] word_board0;
  } in_word_t;

  // One integrated power sum of a dump.
  typedef struct packed {
    logic [IdxW-1:0] sum_index;
    logic [AccW-1:0] power_sum;
    logic            last_of_dump;
  } out_sum_t;

  // Power of one signed 4-bit complex value: im in the upper nibble, re in the lower.
  function automatic logic [PowerW-1:0] pair_power(input logic [PairW-1:0] pair);
    logic signed [3:0] re;
    logic signed [3:0] im;
    logic signed [7:0] re_sq;
    logic signed [7:0] im_sq;
    re    = pair[3:0];
    im    = pair[7:4];
    re_sq = 8'(re) * 8'(re);
    im_sq = 8'(im) * 8'(im);
    return PowerW'(re_sq) + PowerW'(im_sq);
  endfunction

endpackage
`default_nettype wire

// File: hdl/packed_4bit_power_integrator_top.sv
// Top level of the packed 4-bit power integrator (integrate and dump of voltage powers).
`timescale 1ns / 1ps
`default_nettype none
// The block takes one word per clock cycle while in_stall_o is low, each
// holding one time sample of one channel as five 32-bit board words; a word
// passes from the input register straight into the accumulators. For
// every antenna and polarization it adds re squared plus im squared into a
// 26-bit accumulator. When the configured number of samples has been summed,
// all sums (4 per board, 20 for five boards) are copied into a dump buffer in
// the same cycle and the accumulators restart from the power of the next
// sample. The dump buffer drains through the output register at one sum per
// cycle in index order while out_stall_i is low, and the last sum carries
// last_of_dump. Integration continues while a dump drains; only a word that
// would close the next bin before the dump buffer is empty waits in the input
// register. A configured bin length of 0 behaves as 1, and values above
// MAX_SAMPLES_PER_BIN behave as that maximum.
// Write the configuration register only while no word is in flight.
module packed_4bit_power_integrator_top #(
  parameter int unsigned MAX_SAMPLES_PER_BIN = p4pi_pkg::MaxSamplesDefault,
  parameter int unsigned NUM_BOARDS          = p4pi_pkg::NumBoardsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire p4pi_pkg::in_word_t       in_data_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      p4pi_pkg::out_sum_t       out_data_o,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [p4pi_pkg::SpbW-1:0] cfg_data_i
);
  import p4pi_pkg::*;

  // Boards beyond the five input words are never used.
  localparam int unsigned BoardsUsed = (NUM_BOARDS < BoardPorts) ? NUM_BOARDS : BoardPorts;
  localparam int unsigned NumSums    = SumsPerWord * BoardsUsed;
  localparam int unsigned RdW        = $clog2(NumSums);
  localparam int unsigned CntW       = $clog2(MAX_SAMPLES_PER_BIN + 1);
  localparam int unsigned LenW       = (CntW > SpbW) ? CntW : SpbW;

  `include "packed_4bit_power_integrator_top_macros.svh"

  // Configuration register; writes are always taken.
  logic [SpbW-1:0] spb_q;

  // Input register.
  logic     in_valid_q;
  in_word_t in_data_q;

  // Integration state.
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_inc;
  logic [AccW-1:0] acc_q [NumSums];
  logic [AccW-1:0] acc_sum [NumSums];

  // Dump buffer and its read pointer.
  logic [AccW-1:0] dump_q [NumSums];
  logic            dump_busy_q;
  logic [RdW-1:0]  rd_idx_q;
  logic            rd_last;

  // Output register.
  logic     out_valid_q;
  out_sum_t out_data_q;

  logic [WordW-1:0]  board_word [BoardPorts];
  logic [PowerW-1:0] power [NumSums];
  logic [LenW-1:0]   eff_len;
  logic [LenW-1:0]   spb_ext;
  logic              bin_done;
  logic              consume;
  logic              dump_take;
  logic              out_load;
  logic              out_pop;
  logic              in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q <= SpbReset;
    end else if (cfg_valid_i) begin
      spb_q <= cfg_data_i;
    end
  end

  // Clamp the bin length to the supported range.
  always_comb begin
    spb_ext = LenW'(spb_q);
    if (spb_q == '0) begin
      eff_len = LenW'(1);
    end else if (spb_ext > LenW'(MAX_SAMPLES_PER_BIN)) begin
      eff_len = LenW'(MAX_SAMPLES_PER_BIN);
    end else begin
      eff_len = spb_ext;
    end
  end

  assign count_inc = count_q + CntW'(1);
  assign bin_done  = (LenW'(count_inc) >= eff_len);

  // A word leaves the input register unless it closes a bin while the previous
  // dump is still draining.
  assign consume    = in_valid_q && !(bin_done && dump_busy_q);
  assign dump_take  = consume && bin_done;
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  // Unpack the words and square the nibbles, one lane per accumulator.
  always_comb begin
    board_word[0] = in_data_q.word_board0;
    board_word[1] = in_data_q.word_board1;
    board_word[2] = in_data_q.word_board2;
    board_word[3] = in_data_q.word_board3;
    board_word[4] = in_data_q.word_board4;
  end

  for (genvar s = 0; s < NumSums; s++) begin : g_lane
    assign power[s]   = pair_power(board_word[s / SumsPerWord][(s % SumsPerWord) * PairW +: PairW]);
    assign acc_sum[s] = acc_q[s] + AccW'(power[s]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[s] <= '0;
      end else if (consume) begin
        acc_q[s] <= bin_done ? '0 : acc_sum[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (dump_take) begin
        dump_q[s] <= acc_sum[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (consume) begin
      count_q <= bin_done ? '0 : count_inc;
    end
  end

  // Drain the dump buffer through the output register.
  assign rd_last  = (rd_idx_q == RdW'(NumSums - 1));
  assign out_pop  = out_valid_q && !out_stall_i;
  assign out_load = dump_busy_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_busy_q <= 1'b0;
      rd_idx_q    <= '0;
    end else if (dump_take) begin
      dump_busy_q <= 1'b1;
      rd_idx_q    <= '0;
    end else if (out_load) begin
      dump_busy_q <= !rd_last;
      rd_idx_q    <= rd_last ? '0 : rd_idx_q + RdW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.sum_index    <= IdxW'(rd_idx_q);
      out_data_q.power_sum    <= dump_q[rd_idx_q];
      out_data_q.last_of_dump <= rd_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The last sum of a dump always carries the highest index.
  `P4PI_ASSERT_NOW(a_last_index, out_valid_o && out_data_o.last_of_dump,
                   out_data_o.sum_index == IdxW'(NumSums - 1), "last sum has wrong index")

  // A new bin never overwrites a dump that is still draining.
  `P4PI_ASSERT_NOW(a_no_overwrite, dump_busy_q, !dump_take, "dump buffer overwritten")

  // Sums leave the buffer in strictly increasing order.
  `P4PI_ASSERT_NEXT(a_rd_step, out_load && !rd_last && !dump_take,
                    dump_busy_q && rd_idx_q == $past(rd_idx_q) + RdW'(1),
                    "dump read pointer skipped")

  // Closing a bin restarts the sample count.
  `P4PI_ASSERT_NEXT(a_count_clear, dump_take, count_q == '0, "sample count not cleared")

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the packed 4-bit power integrator with a built-in power predictor.
`timescale 1ns / 1ps
module tb;
  import p4pi_pkg::*;

  localparam int unsigned NumSums     = BoardPorts * SumsPerWord;
  // Cycles allowed for a word without a dump to leave the input register and
  // land in the accumulators before the register may be rewritten.
  localparam int          SettleCycles = 8;
  localparam int          RandomItems  = 380;
  localparam int          ReportLimit  = 10;

  // Clock, reset and the ports of the block.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_sum_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [SpbW-1:0] cfg_data = '0;

  // Words waiting to be sent and sums waiting to arrive.
  in_word_t    pending_words[$];
  out_sum_t    expected_sums[$];
  int          pushed_count = 0;
  int          accepted_count = 0;
  int          mismatch_count = 0;

  // Predictor state: a private copy of the accumulators, the sample count and
  // the bin length register.
  logic [AccW-1:0] power_acc [NumSums];
  int unsigned     bin_count = 0;
  logic [SpbW-1:0] bin_length_reg = SpbReset;

  // Idle shaping for both sides.
  int          send_gap = 0;
  int          stall_left = 0;
  bit          calm_sender = 1'b0;
  bit          calm_receiver = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  packed_4bit_power_integrator_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    for (int i = 0; i < NumSums; i++) power_acc[i] = '0;
  end

  // Adds the powers of one accepted word into the predicted accumulators and,
  // when the bin closes, queues the twenty sums that the dump must deliver.
  task automatic integrate_sample(input in_word_t sample);
    logic [BoardPorts*WordW-1:0] flat;
    logic [WordW-1:0]            board_word;
    logic signed [3:0]           re;
    logic signed [3:0]           im;
    int                          pw;
    int                          slot;
    int unsigned                 bin_len;
    out_sum_t                    s;
    flat = sample;
    for (int b = 0; b < BoardPorts; b++) begin
      board_word = flat[WordW*b +: WordW];
      for (int p = 0; p < SumsPerWord; p++) begin
        re   = board_word[8*p +: 4];
        im   = board_word[8*p + 4 +: 4];
        pw   = int'(re) * int'(re) + int'(im) * int'(im);
        slot = SumsPerWord * b + p;
        power_acc[slot] = power_acc[slot] + AccW'(pw);
      end
    end
    bin_count++;
    // A length of zero acts as one; lengths above the maximum are clipped.
    bin_len = (bin_length_reg == '0) ? 1 : int'(bin_length_reg);
    if (bin_len > MaxSamplesDefault) bin_len = MaxSamplesDefault;
    if (bin_count >= bin_len) begin
      for (int k = 0; k < NumSums; k++) begin
        s.sum_index    = IdxW'(k);
        s.power_sum    = power_acc[k];
        s.last_of_dump = (k == NumSums - 1);
        expected_sums.push_back(s);
        power_acc[k] = '0;
      end
      bin_count = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input out_sum_t want, input out_sum_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("%0t: %s: expected idx %0d sum %0d last %0b, got idx %0d sum %0d last %0b",
               $realtime, what, want.sum_index, want.power_sum, want.last_of_dump,
               got.sum_index, got.power_sum, got.last_of_dump);
  endtask

  task automatic check_sum(input out_sum_t got);
    out_sum_t want;
    if (expected_sums.size() == 0) begin
      note_mismatch("sum with no dump pending", '0, got);
      return;
    end
    want = expected_sums.pop_front();
    if (got.sum_index !== want.sum_index || got.power_sum !== want.power_sum ||
        got.last_of_dump !== want.last_of_dump)
      note_mismatch("power sum mismatch", want, got);
  endtask

  // Mostly back to back, now and then a short pause, rarely a long one.
  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Sender: presents the next queued word and holds it while stalled.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        integrate_sample(in_data);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
          if ($urandom_range(0, 19) == 0) calm_sender = !calm_sender;
          send_gap = calm_sender ? 0 : draw_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every accepted sum and stalls at random.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_sum(out_data);
      if (stall_left > 0) stall_left--;
      else if (!calm_receiver && $urandom_range(0, 99) < 20) stall_left = draw_idle() + 1;
      if ($urandom_range(0, 63) == 0) calm_receiver = !calm_receiver;
      out_stall <= (stall_left > 0);
    end
  end

  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] w;
    logic [3:0]       corner [4];
    corner = '{4'h8, 4'h7, 4'h0, 4'hF};
    if ($urandom_range(0, 99) < 70) return $urandom;
    // Words built only from the corner nibbles: most negative, most positive,
    // zero and minus one.
    for (int n = 0; n < 8; n++) w[4*n +: 4] = corner[$urandom_range(0, 3)];
    return w;
  endfunction

  task automatic push_word(input in_word_t w);
    pending_words.push_back(w);
    pushed_count++;
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++)
      push_word({random_word(), random_word(), random_word(), random_word(), random_word()});
  endtask

  // Waits until every queued word is accepted and every predicted sum has
  // come, then lets words without a dump settle inside the block.
  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_count != pushed_count || expected_sums.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_bin_length(input logic [SpbW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    bin_length_reg = value;
  endtask

  initial begin
    int random_sent;
    logic [SpbW-1:0] bin_len;
    int r;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A few words under the reset length, then the length is lowered mid bin
    // so that the next word closes a bin of four samples.
    push_random(3);
    wait_drained();
    write_bin_length(SpbW'(1));

    // One sample per bin: the nibble extremes one at a time.
    push_word({5{32'h00000000}});
    push_word({5{32'hFFFFFFFF}});
    push_word({5{32'h88888888}});
    push_word({5{32'h77777777}});
    push_word({32'h88888888, 32'h77777777, 32'hFFFFFFFF, 32'h00000000, 32'h78F08F07});
    push_word({32'h87878787, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h12345678, 32'h9ABCDEF0});
    push_word({32'h80000008, 32'h08000080, 32'h00800800, 32'h00088000, 32'h7FFFFFF7});
    push_random(1);
    wait_drained();

    // A zero length behaves as one.
    write_bin_length('0);
    push_random(3);
    wait_drained();

    // The largest register value is clipped; the sums build up at the worst
    // power per sample and are dumped once the length drops below the count.
    write_bin_length('1);
    for (int i = 0; i < 6; i++) push_word({5{32'h88888888}});
    wait_drained();
    write_bin_length(SpbW'(MaxSamplesDefault));
    push_word({5{32'h88888888}});
    push_word({5{32'h77777777}});
    wait_drained();
    write_bin_length(SpbW'(3));
    push_random(1);
    wait_drained();

    // Random phases, mostly short bins so that dumps are frequent and often
    // overlap the next bin. Each phase starts from a fully drained block.
    random_sent = 0;
    while (random_sent < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 10)      bin_len = '0;
      else if (r < 20) bin_len = SpbW'(1);
      else if (r < 80) bin_len = SpbW'($urandom_range(2, 12));
      else             bin_len = SpbW'($urandom_range(13, 40));
      write_bin_length(bin_len);
      r = $urandom_range(8, 40);
      push_random(r);
      random_sent += r;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
